>>> sv/tssm_pkg.sv
// Shared types and constants of the transport sync controller.
// No dependencies; every other file imports this package.
`default_nettype none

package tssm_pkg;

	localparam int MAX_CLIENTS = 16;
	localparam int ID_W        = 4;
	localparam int CNT_CLOG    = $clog2(MAX_CLIENTS + 1);
	localparam int CNT_W       = (CNT_CLOG >= 5) ? CNT_CLOG : 5;

	localparam int TIME_W   = 32;
	localparam int FRAME_W  = 32;
	localparam int PERIOD_W = 14;
	localparam int RATE_W   = 19;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;

	localparam int US_W    = 20;
	localparam int PROD_W  = 34;
	localparam int DIVC_W  = 6;

	localparam logic [US_W-1:0]     US_PER_SEC  = US_W'(1000000);
	localparam logic [TIME_W-1:0]   TIMEOUT_RST = TIME_W'(2000000);
	localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(1024);
	localparam logic [RATE_W-1:0]   RATE_RST    = RATE_W'(48000);

	typedef enum logic [2:0] {
		OP_PERIOD_END = 3'd0,
		OP_COMMAND    = 3'd1,
		OP_READY      = 3'd2,
		OP_SET_SYNC   = 3'd3,
		OP_RESET_SYNC = 3'd4,
		OP_ACTIVATE   = 3'd5,
		OP_EXIT       = 3'd6,
		OP_LOCATE     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_STOPPED  = 2'd0,
		ST_STARTING = 2'd1,
		ST_ROLLING  = 2'd2
	} run_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT = 2'd0,
		CFG_PERIOD  = 2'd1,
		CFG_RATE    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic capture;
		logic exec_ev;
		logic div_start;
		logic exec_pe;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pe_op;
		logic div_done;
	} ctrl_sts_t;

endpackage

`default_nettype wire

>>> sv/tssm_div.sv
// Period length in microseconds: period_frames * 1e6 / sample_rate.
// Multiplies on start, then a restoring divider runs, one quotient bit per cycle. Uses tssm_pkg.
`default_nettype none

module tssm_div
	import tssm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [PERIOD_W-1:0] period,
	input  wire logic [RATE_W-1:0]   rate,
	output logic      [PROD_W-1:0]   quot,
	output logic                     done
);

	logic                busy_q;
	logic                done_q;
	logic [DIVC_W-1:0]   cnt_q;
	logic [PROD_W-1:0]   quo_q;
	logic [RATE_W-1:0]   rem_q;
	logic [RATE_W-1:0]   den_q;
	logic [RATE_W:0]     shifted;
	logic [RATE_W+1:0]   trial;

	assign shifted = {rem_q, quo_q[PROD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIVC_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIVC_W'(1);
				if (cnt_q == DIVC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= PROD_W'(period) * PROD_W'(US_PER_SEC);
			rem_q <= '0;
			den_q <= (rate == '0) ? RATE_W'(1) : rate;
		end else if (busy_q) begin
			if (!trial[RATE_W+1]) begin
				rem_q <= trial[RATE_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[RATE_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quo_q;
	assign done = done_q;

endmodule

`default_nettype wire

>>> sv/tssm_dp.sv
// Datapath: config registers, client masks, sync counters, timeout and frame position.
// Holds the period divider and the result register. Uses tssm_pkg and tssm_div.
`default_nettype none

module tssm_dp
	import tssm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctrl_cmd_t            cmd,
	output ctrl_sts_t                 sts,
	input  wire logic [2:0]           in_op,
	input  wire logic [ID_W-1:0]      in_id,
	input  wire logic                 in_start,
	input  wire logic                 in_dead,
	input  wire logic [FRAME_W-1:0]   in_loc,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output logic [1:0]                out_state,
	output logic [FRAME_W-1:0]        out_frame,
	output logic [4:0]                out_left,
	output logic                      out_newpos,
	output logic                      out_status
);

	logic [TIME_W-1:0]      timeout_q;
	logic [PERIOD_W-1:0]    period_q;
	logic [RATE_W-1:0]      rate_q;

	op_t                    op_q;
	logic [ID_W-1:0]        id_q;
	logic                   start_q;
	logic                   dead_q;
	logic [FRAME_W-1:0]     loc_q;

	run_state_t             rs_q, n_rs;
	logic                   latest_q, n_latest;
	logic                   prev_q, n_prev;
	logic [MAX_CLIENTS-1:0] ss_q, n_ss;
	logic [MAX_CLIENTS-1:0] act_q, n_act;
	logic [MAX_CLIENTS-1:0] act_ss_q, n_act_ss;
	logic [MAX_CLIENTS-1:0] poll_q, n_poll;
	logic [CNT_W-1:0]       cnt_q, n_cnt;
	logic [CNT_W-1:0]       remain_q, n_remain;
	logic [TIME_W-1:0]      time_q, n_time;
	logic [FRAME_W-1:0]     cur_q, n_cur;
	logic [FRAME_W-1:0]     next_q, n_next;
	logic                   loc_pend_q, n_loc_pend;
	logic [FRAME_W-1:0]     loc_val_q, n_loc_val;
	logic                   pos_pend_q, n_pos_pend;
	logic                   pos_chg_q, n_pos_chg;
	logic                   status_q, n_status;

	logic [1:0]             ostate_q;
	logic [FRAME_W-1:0]     oframe_q;
	logic [4:0]             oleft_q;
	logic                   opos_q;
	logic                   ostat_q;

	logic [PROD_W-1:0]      per_us;
	logic                   div_done;
	logic [MAX_CLIENTS-1:0] bit_v;
	logic                   id_ok;

	tssm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.period (period_q),
		.rate   (rate_q),
		.quot   (per_us),
		.done   (div_done)
	);

	assign sts.pe_op    = (op_q == OP_PERIOD_END);
	assign sts.div_done = div_done;

	always_comb begin
		for (int i = 0; i < MAX_CLIENTS; i++) begin
			bit_v[i] = (32'(id_q) == i);
		end
		id_ok = (32'(id_q) < MAX_CLIENTS);
	end

	always_comb begin
		logic cmd_new;
		cmd_new    = 1'b0;
		n_rs       = rs_q;
		n_latest   = latest_q;
		n_prev     = prev_q;
		n_ss       = ss_q;
		n_act      = act_q;
		n_act_ss   = act_ss_q;
		n_poll     = poll_q;
		n_cnt      = cnt_q;
		n_remain   = remain_q;
		n_time     = time_q;
		n_cur      = cur_q;
		n_next     = next_q;
		n_loc_pend = loc_pend_q;
		n_loc_val  = loc_val_q;
		n_pos_pend = pos_pend_q;
		n_pos_chg  = pos_chg_q;
		n_status   = status_q;

		if (cmd.exec_pe) begin
			n_status  = 1'b0;
			n_cur     = next_q;
			n_pos_chg = pos_pend_q;
			if (rs_q == ST_STARTING) begin
				if (remain_q == '0) begin
					n_rs = ST_ROLLING;
				end else if ({2'b00, time_q} > per_us) begin
					n_time = time_q - per_us[TIME_W-1:0];
				end else begin
					n_time = '0;
					n_rs   = ST_ROLLING;
				end
			end
			cmd_new = (latest_q != prev_q);
			n_prev  = latest_q;
			unique case (n_rs)
				ST_STOPPED: begin
					if (cmd_new && latest_q) begin
						if (cnt_q != '0) begin
							n_rs     = ST_STARTING;
							n_poll   = poll_q | act_ss_q;
							n_remain = cnt_q;
							n_time   = timeout_q;
						end else begin
							n_rs = ST_ROLLING;
						end
					end
				end
				ST_STARTING: begin
					if (cmd_new && !latest_q) begin
						n_rs = ST_STOPPED;
						if (remain_q != '0) begin
							n_poll   = poll_q & ~act_ss_q;
							n_remain = '0;
							n_time   = '0;
						end
					end else if (n_pos_chg) begin
						if (cnt_q != '0) begin
							n_poll   = poll_q | act_ss_q;
							n_remain = cnt_q;
							n_time   = timeout_q;
						end else begin
							n_rs = ST_ROLLING;
						end
					end
				end
				ST_ROLLING: begin
					if (cmd_new && !latest_q) begin
						n_rs = ST_STOPPED;
						if (remain_q != '0) begin
							n_poll   = poll_q & ~act_ss_q;
							n_remain = '0;
							n_time   = '0;
						end
					end else if (n_pos_chg && (cnt_q != '0)) begin
						n_rs     = ST_STARTING;
						n_poll   = poll_q | act_ss_q;
						n_remain = cnt_q;
						n_time   = timeout_q;
					end
				end
				default: begin
					n_rs = rs_q;
				end
			endcase
			n_next     = (n_rs == ST_ROLLING) ? n_cur + FRAME_W'(period_q) : n_cur;
			n_pos_pend = 1'b0;
			if (loc_pend_q) begin
				n_next     = loc_val_q;
				n_pos_pend = 1'b1;
				n_loc_pend = 1'b0;
			end
		end else if (cmd.exec_ev) begin
			n_status = 1'b0;
			unique case (op_q)
				OP_COMMAND: begin
					n_latest = start_q;
				end
				OP_READY: begin
					if (id_ok && ((poll_q & bit_v) != '0)) begin
						n_poll = poll_q & ~bit_v;
						if (remain_q != '0) n_remain = remain_q - CNT_W'(1);
					end
				end
				OP_SET_SYNC: begin
					if (id_ok) begin
						if ((ss_q & bit_v) == '0) begin
							n_ss = ss_q | bit_v;
							if (((act_q & bit_v) != '0) && ((act_ss_q & bit_v) == '0)) begin
								n_act_ss = act_ss_q | bit_v;
								n_cnt    = cnt_q + CNT_W'(1);
							end
						end
						if ((n_act_ss & bit_v) != '0) begin
							n_time = timeout_q;
							if ((poll_q & bit_v) == '0) begin
								n_poll   = poll_q | bit_v;
								n_remain = remain_q + CNT_W'(1);
							end
							if (rs_q == ST_ROLLING) n_rs = ST_STARTING;
						end
					end
				end
				OP_RESET_SYNC: begin
					if (id_ok && ((ss_q & bit_v) != '0)) begin
						if ((act_ss_q & bit_v) != '0) begin
							if ((poll_q & bit_v) != '0) begin
								n_poll = poll_q & ~bit_v;
								if (remain_q != '0) n_remain = remain_q - CNT_W'(1);
							end
							n_act_ss = act_ss_q & ~bit_v;
							if (cnt_q != '0) n_cnt = cnt_q - CNT_W'(1);
						end
						n_ss = ss_q & ~bit_v;
					end else begin
						n_status = 1'b1;
					end
				end
				OP_ACTIVATE: begin
					if (id_ok && ((act_q & bit_v) == '0)) begin
						n_act = act_q | bit_v;
						if (((ss_q & bit_v) != '0) && ((act_ss_q & bit_v) == '0)) begin
							n_act_ss = act_ss_q | bit_v;
							n_cnt    = cnt_q + CNT_W'(1);
							n_time   = timeout_q;
							if ((poll_q & bit_v) == '0) begin
								n_poll   = poll_q | bit_v;
								n_remain = remain_q + CNT_W'(1);
							end
							if (rs_q == ST_ROLLING) n_rs = ST_STARTING;
						end
					end
				end
				OP_EXIT: begin
					if (id_ok) begin
						if ((ss_q & bit_v) != '0) begin
							if ((act_ss_q & bit_v) != '0) begin
								if ((poll_q & bit_v) != '0) begin
									n_poll = poll_q & ~bit_v;
									if (remain_q != '0) n_remain = remain_q - CNT_W'(1);
								end
								n_act_ss = act_ss_q & ~bit_v;
								if (cnt_q != '0) n_cnt = cnt_q - CNT_W'(1);
							end
							if (dead_q) n_ss = ss_q & ~bit_v;
						end
						n_act = act_q & ~bit_v;
					end
				end
				OP_LOCATE: begin
					n_loc_pend = 1'b1;
					n_loc_val  = loc_q;
				end
				default: begin
					n_status = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			period_q   <= PERIOD_RST;
			rate_q     <= RATE_RST;
			rs_q       <= ST_STOPPED;
			latest_q   <= 1'b0;
			prev_q     <= 1'b0;
			ss_q       <= '0;
			act_q      <= '0;
			act_ss_q   <= '0;
			poll_q     <= '0;
			cnt_q      <= '0;
			remain_q   <= '0;
			time_q     <= '0;
			cur_q      <= '0;
			next_q     <= '0;
			loc_pend_q <= 1'b0;
			loc_val_q  <= '0;
			pos_pend_q <= 1'b0;
			pos_chg_q  <= 1'b0;
			status_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TIMEOUT: timeout_q <= cfg_data[TIME_W-1:0];
					CFG_PERIOD:  period_q  <= cfg_data[PERIOD_W-1:0];
					CFG_RATE:    rate_q    <= cfg_data[RATE_W-1:0];
					default:     timeout_q <= timeout_q;
				endcase
			end
			rs_q       <= n_rs;
			latest_q   <= n_latest;
			prev_q     <= n_prev;
			ss_q       <= n_ss;
			act_q      <= n_act;
			act_ss_q   <= n_act_ss;
			poll_q     <= n_poll;
			cnt_q      <= n_cnt;
			remain_q   <= n_remain;
			time_q     <= n_time;
			cur_q      <= n_cur;
			next_q     <= n_next;
			loc_pend_q <= n_loc_pend;
			loc_val_q  <= n_loc_val;
			pos_pend_q <= n_pos_pend;
			pos_chg_q  <= n_pos_chg;
			status_q   <= n_status;
		end
	end

	// input word and result word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(in_op);
			id_q    <= in_id;
			start_q <= in_start;
			dead_q  <= in_dead;
			loc_q   <= in_loc;
		end
		if (cmd.load_out) begin
			ostate_q <= rs_q;
			oframe_q <= cur_q;
			oleft_q  <= remain_q[4:0];
			opos_q   <= pos_chg_q;
			ostat_q  <= status_q;
		end
	end

	assign out_state  = ostate_q;
	assign out_frame  = oframe_q;
	assign out_left   = oleft_q;
	assign out_newpos = opos_q;
	assign out_status = ostat_q;

	a_poll_in_active: assert property (@(posedge clk) disable iff (!arst_n)
		(poll_q & ~act_ss_q) == '0)
		else $error("polled client not an active slow-sync client");

	a_act_ss_masks: assert property (@(posedge clk) disable iff (!arst_n)
		(act_ss_q & ~(ss_q & act_q)) == '0)
		else $error("active slow-sync mask outside slow-sync and active masks");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(act_ss_q) == 32'(cnt_q))
		else $error("sync client count out of step with mask");

endmodule

`default_nettype wire

>>> sv/tssm_ctrl.sv
// Sequencer: handshakes, dispatch of events and period ends, result register valid.
// Drives datapath commands, reads datapath status. Uses tssm_pkg.
`default_nettype none

module tssm_ctrl
	import tssm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_DIV,
		S_APPLY,
		S_RESP
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	assign s_tready      = (state_q == S_IDLE);
	assign m_tvalid      = m_tvalid_q;
	assign cmd.capture   = s_tvalid && (state_q == S_IDLE);
	assign cmd.exec_ev   = (state_q == S_DISPATCH) && !sts.pe_op;
	assign cmd.div_start = (state_q == S_DISPATCH) && sts.pe_op;
	assign cmd.exec_pe   = (state_q == S_APPLY);
	assign cmd.load_out  = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					state_q <= sts.pe_op ? S_DIV : S_RESP;
				end
				S_DIV: begin
					if (sts.div_done) state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.exec_ev, cmd.div_start, cmd.exec_pe, cmd.load_out}))
		else $error("more than one datapath command at once");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the wait state");

	a_start_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == S_DIV))
		else $error("divider started without waiting for it");

endmodule

`default_nettype wire

>>> sv/transport_sync_state_machine.sv
// Each input word is captured, dispatched and its result loaded into the output register;
// a period end first runs the multiply and the 34-step restoring divider, then is applied.
// Words are taken one at a time; a new word is taken while the previous result still waits
// on the output register, and its own result load stalls until that one is taken.
// Reset (arst_n low): transport stopped, masks, counters and frames cleared,
// configuration registers at their default values.
`default_nettype none

module transport_sync_state_machine
	import tssm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [39:0]          s_tdata,   // client[3:0], start_cmd, client_dead, locate_frame[31:0], zero pad
	input  wire logic [2:0]           s_tuser,   // op
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [47:0]               m_tdata,   // xport_state[1:0], frame_position[31:0], sync_left[4:0], new_position, status, zero pad
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	ctrl_cmd_t          cmd;
	ctrl_sts_t          sts;
	logic [1:0]         out_state;
	logic [FRAME_W-1:0] out_frame;
	logic [4:0]         out_left;
	logic               out_newpos;
	logic               out_status;

	tssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tssm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (s_tuser),
		.in_id      (s_tdata[3:0]),
		.in_start   (s_tdata[4]),
		.in_dead    (s_tdata[5]),
		.in_loc     (s_tdata[37:6]),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_state  (out_state),
		.out_frame  (out_frame),
		.out_left   (out_left),
		.out_newpos (out_newpos),
		.out_status (out_status)
	);

	assign m_tdata = {7'b0, out_status, out_newpos, out_left, out_frame, out_state};

endmodule

`default_nettype wire

>>> tb/sv/tssm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the transport sync controller: tracks register writes, predicts one
// result word per accepted input word and compares results in order, field by field.
// Depends on tssm_pkg for operation, state and register codes.
module tssm_checker
	import tssm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [39:0]          s_tdata,   // client[3:0], start_cmd, client_dead, locate_frame[31:0], zero pad
	input  wire logic [2:0]           s_tuser,   // op
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [47:0]          m_tdata,   // xport_state[1:0], frame_position[31:0], sync_left[4:0], new_position, status, zero pad
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output int                        errors,
	output int                        outstanding
);

	typedef struct packed {
		logic                 status;
		logic                 new_pos;
		logic [4:0]           sync_left;
		logic [FRAME_W-1:0]   frame;
		logic [1:0]           state;
	} transport_word_t;

	run_state_t             xport;
	logic                   cmd_latest, cmd_handled;
	logic [MAX_CLIENTS-1:0] sync_mark, active, active_sync, polled;
	int                     sync_clients, sync_pending;
	logic [TIME_W-1:0]      budget_us;
	logic [FRAME_W-1:0]     cur_frame, nxt_frame, loc_frame;
	logic                   loc_req, reloc_next, reloc_now;

	logic [TIME_W-1:0]      cfg_timeout;
	logic [PERIOD_W-1:0]    cfg_period;
	logic [RATE_W-1:0]      cfg_rate;

	transport_word_t        expected_q[$];
	int                     fails = 0;
	int                     waiting = 0;
	int                     result_idx = 0;

	assign errors      = fails;
	assign outstanding = waiting;

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("[%0t] result %0d: mismatch in %s: got 0x%0h, expected 0x%0h",
			$time, result_idx, what, got, want);
		fails++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, 48'(got), 48'(want));
	endtask

	task automatic open_poll();
		polled |= active_sync;
		sync_pending = $countones(active_sync);
		budget_us = cfg_timeout;
	endtask

	task automatic close_poll();
		polled &= ~active_sync;
		sync_pending = 0;
		budget_us = '0;
	endtask

	task automatic poll_one(input logic [MAX_CLIENTS-1:0] sel);
		budget_us = cfg_timeout;
		if ((polled & sel) == '0) begin
			polled |= sel;
			sync_pending++;
		end
		if (xport == ST_ROLLING)
			xport = ST_STARTING;
	endtask

	task automatic unpoll_one(input logic [MAX_CLIENTS-1:0] sel);
		if ((polled & sel) != '0) begin
			polled &= ~sel;
			if (sync_pending > 0)
				sync_pending--;
		end
	endtask

	task automatic drop_one(input logic [MAX_CLIENTS-1:0] sel);
		unpoll_one(sel);
		active_sync &= ~sel;
		if (sync_clients > 0)
			sync_clients--;
	endtask

	task automatic end_of_period();
		logic            cmd_new;
		longint unsigned per_us;
		cur_frame = nxt_frame;
		reloc_now = reloc_next;
		per_us = (64'(cfg_period) * 64'd1000000) /
			((cfg_rate == '0) ? 64'd1 : 64'(cfg_rate));
		if (xport == ST_STARTING) begin
			if (sync_pending == 0)
				xport = ST_ROLLING;
			else if (64'(budget_us) > per_us)
				budget_us = 32'(64'(budget_us) - per_us);
			else begin
				budget_us = '0;
				xport = ST_ROLLING;
			end
		end
		cmd_new = (cmd_latest != cmd_handled);
		cmd_handled = cmd_latest;
		if (cmd_new && cmd_latest && xport == ST_STOPPED) begin
			if (sync_clients != 0) begin
				xport = ST_STARTING;
				open_poll();
			end else
				xport = ST_ROLLING;
		end else if (cmd_new && !cmd_latest && xport != ST_STOPPED) begin
			xport = ST_STOPPED;
			if (sync_pending != 0)
				close_poll();
		end else if (reloc_now && xport == ST_STARTING) begin
			if (sync_clients != 0)
				open_poll();
			else
				xport = ST_ROLLING;
		end else if (reloc_now && xport == ST_ROLLING && sync_clients != 0) begin
			xport = ST_STARTING;
			open_poll();
		end
		nxt_frame = (xport == ST_ROLLING) ? cur_frame + FRAME_W'(cfg_period) : cur_frame;
		reloc_next = 1'b0;
		if (loc_req) begin
			nxt_frame = loc_frame;
			reloc_next = 1'b1;
			loc_req = 1'b0;
		end
	endtask

	task automatic apply_word(input op_t op, input logic [ID_W-1:0] id, input logic start,
			input logic dead, input logic [FRAME_W-1:0] loc, output transport_word_t res);
		logic [MAX_CLIENTS-1:0] sel;
		logic                   bad;
		sel = '0;
		sel[id] = 1'b1;
		bad = 1'b0;
		case (op)
			OP_PERIOD_END: end_of_period();
			OP_COMMAND:    cmd_latest = start;
			OP_READY:      unpoll_one(sel);
			OP_SET_SYNC: begin
				if ((sync_mark & sel) == '0) begin
					sync_mark |= sel;
					if ((active & sel) != '0 && (active_sync & sel) == '0) begin
						active_sync |= sel;
						sync_clients++;
					end
				end
				if ((active_sync & sel) != '0)
					poll_one(sel);
			end
			OP_RESET_SYNC: begin
				if ((sync_mark & sel) != '0) begin
					if ((active_sync & sel) != '0)
						drop_one(sel);
					sync_mark &= ~sel;
				end else
					bad = 1'b1;
			end
			OP_ACTIVATE: begin
				if ((active & sel) == '0) begin
					active |= sel;
					if ((sync_mark & sel) != '0 && (active_sync & sel) == '0) begin
						active_sync |= sel;
						sync_clients++;
						poll_one(sel);
					end
				end
			end
			OP_EXIT: begin
				if ((sync_mark & sel) != '0) begin
					if ((active_sync & sel) != '0)
						drop_one(sel);
					if (dead)
						sync_mark &= ~sel;
				end
				active &= ~sel;
			end
			default: begin
				loc_req = 1'b1;
				loc_frame = loc;
			end
		endcase
		res.state     = xport;
		res.frame     = cur_frame;
		res.sync_left = sync_pending[4:0];
		res.new_pos   = reloc_now;
		res.status    = bad;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		transport_word_t got, want;
		if (!arst_n) begin
			xport        = ST_STOPPED;
			cmd_latest   = 1'b0;
			cmd_handled  = 1'b0;
			sync_mark    = '0;
			active       = '0;
			active_sync  = '0;
			polled       = '0;
			sync_clients = 0;
			sync_pending = 0;
			budget_us    = '0;
			cur_frame    = '0;
			nxt_frame    = '0;
			loc_frame    = '0;
			loc_req      = 1'b0;
			reloc_next   = 1'b0;
			reloc_now    = 1'b0;
			cfg_timeout  = TIMEOUT_RST;
			cfg_period   = PERIOD_RST;
			cfg_rate     = RATE_RST;
			expected_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0)
					report_mismatch("unexpected result word", m_tdata, '0);
				else begin
					want = expected_q.pop_front();
					got  = transport_word_t'(m_tdata[40:0]);
					check_field("xport_state", 32'(got.state), 32'(want.state));
					check_field("frame_position", got.frame, want.frame);
					check_field("sync_left", 32'(got.sync_left), 32'(want.sync_left));
					check_field("new_position", 32'(got.new_pos), 32'(want.new_pos));
					check_field("status", 32'(got.status), 32'(want.status));
				end
				result_idx++;
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TIMEOUT: cfg_timeout = cfg_data;
					CFG_PERIOD:  cfg_period  = cfg_data[PERIOD_W-1:0];
					CFG_RATE:    cfg_rate    = cfg_data[RATE_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				apply_word(op_t'(s_tuser), s_tdata[3:0], s_tdata[4], s_tdata[5],
					s_tdata[37:6], want);
				expected_q.push_back(want);
			end
		end
		waiting = expected_q.size();
	end

endmodule

>>> tb/sv/tb_transport_sync_state_machine.sv
`timescale 1ns / 100ps
// Testbench top for the transport sync controller: clock, reset, register writes,
// input words and output stalls; checking is done by tssm_checker.
// Depends on tssm_pkg, transport_sync_state_machine and tssm_checker.
module tb_transport_sync_state_machine;
	import tssm_pkg::*;

	localparam int                   WATCHDOG_LIMIT = 2000;
	localparam int                   SETTLE_CYCLES  = 40;
	localparam int                   NUM_PHASES     = 6;
	localparam int                   PHASE_WORDS    = 104;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;

	localparam logic [TIME_W-1:0] PHASE_TIMEOUT [NUM_PHASES] =
		'{32'd0, 32'hFFFF_FFFF, 32'd50000, 32'd100000, 32'd1, 32'd30000};
	localparam logic [PERIOD_W-1:0] PHASE_PERIOD [NUM_PHASES] =
		'{14'd1, 14'd8192, 14'd1024, 14'd8192, 14'd1, 14'd256};
	localparam logic [RATE_W-1:0] PHASE_RATE [NUM_PHASES] =
		'{19'd1, 19'd384000, 19'd48000, 19'd1, 19'd0, 19'd44100};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	wire logic            s_tready;
	logic [39:0]          s_tdata = '0;  // client[3:0], start_cmd, client_dead, locate_frame[31:0], zero pad
	logic [2:0]           s_tuser = '0;  // op
	wire logic            m_tvalid;
	logic                 m_tready = 1'b0;
	wire logic [47:0]     m_tdata;       // xport_state[1:0], frame_position[31:0], sync_left[4:0], new_position, status, zero pad
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int                   errors;
	int                   outstanding;
	int                   words_sent = 0;
	int                   quiet_cycles = 0;
	bit                   idle_on = 1'b0;

	always #5 clk = ~clk;

	transport_sync_state_machine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tssm_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ID_W-1:0] pick_client();
		if ($urandom_range(0, 3) != 0)
			return ID_W'($urandom_range(0, 3));
		return ID_W'($urandom_range(0, MAX_CLIENTS - 1));
	endfunction

	function automatic logic [FRAME_W-1:0] pick_frame();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '1;
		if (r == 1)
			return '0;
		return $urandom();
	endfunction

	task automatic send_word(input op_t op, input logic [ID_W-1:0] id, input logic start,
			input logic dead, input logic [FRAME_W-1:0] loc);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, loc, dead, start, id};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic send_event(input op_t op, input logic [ID_W-1:0] id);
		send_word(op, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_noise();
		int  r;
		op_t op;
		r = $urandom_range(0, 99);
		if (r < 25)      op = OP_PERIOD_END;
		else if (r < 35) op = OP_COMMAND;
		else if (r < 52) op = OP_READY;
		else if (r < 64) op = OP_SET_SYNC;
		else if (r < 72) op = OP_RESET_SYNC;
		else if (r < 84) op = OP_ACTIVATE;
		else if (r < 92) op = OP_EXIT;
		else             op = OP_LOCATE;
		send_word(op, pick_client(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			pick_frame());
	endtask

	// one session: register slow-sync clients, start, answer the poll, then maybe stop and release
	task automatic run_session();
		logic [ID_W-1:0] ids [4];
		int              n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++)
			ids[i] = pick_client();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1)) begin
				send_event(OP_SET_SYNC, ids[i]);
				send_event(OP_ACTIVATE, ids[i]);
			end else begin
				send_event(OP_ACTIVATE, ids[i]);
				send_event(OP_SET_SYNC, ids[i]);
			end
		end
		send_word(OP_COMMAND, pick_client(), 1'b1, 1'($urandom_range(0, 1)), $urandom());
		send_event(OP_PERIOD_END, pick_client());
		for (int i = 0; i < n; i++) begin
			send_event(OP_READY, ids[i]);
			if ($urandom_range(0, 2) == 0)
				send_event(OP_PERIOD_END, pick_client());
		end
		send_event(OP_PERIOD_END, pick_client());
		send_event(OP_PERIOD_END, pick_client());
		if ($urandom_range(0, 2) == 0) begin
			send_word(OP_LOCATE, pick_client(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), pick_frame());
			send_event(OP_PERIOD_END, pick_client());
			send_event(OP_PERIOD_END, pick_client());
			for (int i = 0; i < n; i++)
				send_event(OP_READY, ids[i]);
			send_event(OP_PERIOD_END, pick_client());
		end
		repeat ($urandom_range(0, 3)) send_event(OP_PERIOD_END, pick_client());
		if ($urandom_range(0, 1)) begin
			send_word(OP_COMMAND, pick_client(), 1'b0, 1'($urandom_range(0, 1)), $urandom());
			send_event(OP_PERIOD_END, pick_client());
		end
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: send_word(OP_EXIT, ids[i], 1'($urandom_range(0, 1)), 1'b0, $urandom());
				1: send_word(OP_EXIT, ids[i], 1'($urandom_range(0, 1)), 1'b1, $urandom());
				2: send_event(OP_RESET_SYNC, ids[i]);
				default: ;
			endcase
		end
	endtask

	initial begin : rx_side
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = gap_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : stimulus
		int stop_at;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset register values
		send_word(OP_PERIOD_END, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_RESET_SYNC, 4'd0, 1'b0, 1'b0, '0);   // unmarked client: status set
		send_word(OP_SET_SYNC, 4'd15, 1'b1, 1'b1, '1);
		send_word(OP_ACTIVATE, 4'd15, 1'b0, 1'b1, '0);     // polled while stopped
		send_word(OP_ACTIVATE, 4'd15, 1'b1, 1'b0, '1);     // already active
		send_word(OP_READY, 4'd15, 1'b0, 1'b0, '0);
		send_word(OP_READY, 4'd15, 1'b1, 1'b1, '1);        // not polled any more
		send_word(OP_SET_SYNC, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_ACTIVATE, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_COMMAND, 4'd0, 1'b1, 1'b0, '0);
		send_word(OP_PERIOD_END, 4'd0, 1'b0, 1'b0, '0);    // starting, poll both
		send_word(OP_READY, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_PERIOD_END, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_READY, 4'd15, 1'b0, 1'b0, '0);
		send_word(OP_PERIOD_END, 4'd0, 1'b0, 1'b0, '0);    // all ready: rolling
		send_word(OP_LOCATE, 4'd0, 1'b0, 1'b0, '1);
		send_word(OP_LOCATE, 4'd15, 1'b1, 1'b1, 32'hFFFF_FC00);  // newest locate wins
		send_word(OP_PERIOD_END, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_PERIOD_END, 4'd0, 1'b0, 1'b0, '0);    // relocation restarts poll
		send_word(OP_EXIT, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_EXIT, 4'd15, 1'b0, 1'b1, '0);         // dead: mark cleared
		send_word(OP_PERIOD_END, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_PERIOD_END, 4'd0, 1'b0, 1'b0, '0);    // position wraps
		send_word(OP_RESET_SYNC, 4'd15, 1'b0, 1'b0, '0);
		send_word(OP_RESET_SYNC, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_COMMAND, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_PERIOD_END, 4'd0, 1'b0, 1'b0, '0);
		send_word(OP_COMMAND, 4'd0, 1'b1, 1'b0, '0);
		send_word(OP_PERIOD_END, 4'd0, 1'b0, 1'b0, '0);    // no sync clients: rolls at once

		stop_at = words_sent;
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_reg(CFG_TIMEOUT, PHASE_TIMEOUT[p]);
			write_reg(CFG_PERIOD, CFG_W'(PHASE_PERIOD[p]));
			write_reg(CFG_RATE, CFG_W'(PHASE_RATE[p]));
			if (p == 2)
				write_reg(CFG_SPARE, $urandom());
			idle_on = (p != 2);
			stop_at += PHASE_WORDS;
			while (words_sent < stop_at) begin
				if ($urandom_range(0, 99) < 65)
					run_session();
				else
					repeat ($urandom_range(3, 8)) send_noise();
			end
		end

		settle();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> transport_sync_state_machine.f
sv/tssm_pkg.sv
sv/tssm_div.sv
sv/tssm_dp.sv
sv/tssm_ctrl.sv
sv/transport_sync_state_machine.sv
tb/sv/tssm_checker.sv
tb/sv/tb_transport_sync_state_machine.sv
